// ===== src/float_add_sub_macros.svh =====
// float_add_sub_macros.svh: assertion macros for the adder pipeline.
// No dependencies.
`ifndef FLOAT_ADD_SUB_MACROS_SVH
`define FLOAT_ADD_SUB_MACROS_SVH

// a property that must hold at every edge out of reset
`define FAS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// an implication whose consequent is checked in the cycle after the antecedent
`define FAS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/fas_pkg.sv =====
// fas_pkg: shared constants and stage types for the float adder pipeline.
// No dependencies.
`timescale 1ns / 1ps
package fas_pkg;
	localparam logic [31:0] ExpMask   = 32'h7F80_0000;
	localparam logic [31:0] FracMask  = 32'h007F_FFFF;
	localparam logic [31:0] HiddenBit = 32'h0080_0000;

	typedef struct packed {
		logic [31:0] operand_a;
		logic [31:0] operand_b;
		logic        mode;
	} fas_in_t;

	typedef struct packed {
		logic [31:0] sum_bits;
		logic        overflow;
		logic        underflow;
	} fas_out_t;

	// after alignment: significands and operating mode
	typedef struct packed {
		logic        sign_r;
		logic        sub;
		logic [7:0]  e_big;
		logic [26:0] m_big;
		logic [26:0] m_small;
	} fas_align_t;

	// after add: raw sum
	typedef struct packed {
		logic        sign_r;
		logic [9:0]  e;
		logic [27:0] m;
	} fas_sum_t;

	// after normalize: bit 26 set unless zero
	typedef struct packed {
		logic        sign_r;
		logic        zero;
		logic signed [10:0] e;
		logic [26:0] m;
	} fas_norm_t;
endpackage

// ===== src/fas_stream_if.sv =====
// fas_stream_if: valid/ready channel carrying one payload type.
// No dependencies.
`timescale 1ns / 1ps
interface fas_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/float_add_sub.sv =====
// Channel  | Dir | Payload
// in_ch    | in  | operand_a[32], operand_b[32], mode
// out_ch   | out | sum_bits[32], overflow, underflow
// Four register stages: align (s1), add (s2), normalize (s3), round (s4).
// A beat taken from in_ch passes through s1, s2, s3 and s4 in turn to out_ch.
// One beat enters per cycle when the pipeline advances, which it does whenever the
// output stage is empty or being taken, so a stall freezes all stages in place.
// Reset clears only the stage valid bits.
// float_add_sub: top level of the pipelined single-precision adder.
// Depends on fas_pkg, fas_stream_if, fas_align, fas_norm, fas_round, float_add_sub_macros.svh.
`timescale 1ns / 1ps
`include "float_add_sub_macros.svh"
module float_add_sub import fas_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	fas_stream_if.sink   in_ch,
	fas_stream_if.source out_ch
);
	fas_align_t al_c, al_s1;
	fas_sum_t   sm_s2;
	fas_norm_t  nm_c, nm_s3;
	fas_out_t   rd_c, rd_s4;
	logic v_s1, v_s2, v_s3, v_s4;
	logic adv;

	assign adv = !v_s4 || out_ch.ready;
	assign in_ch.ready = adv;
	assign out_ch.valid = v_s4;
	assign out_ch.data = rd_s4;

	fas_align u_align (.in_item(in_ch.data), .out_item(al_c));
	fas_norm  u_norm  (.in_item(sm_s2), .out_item(nm_c));
	fas_round u_round (.in_item(nm_s3), .out_item(rd_c));

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_ch.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// payload stages; add sits between s1 and s2
	always_ff @(posedge clk) begin
		if (adv) begin
			al_s1 <= al_c;
			sm_s2.sign_r <= al_s1.sign_r;
			sm_s2.e <= {2'b00, al_s1.e_big};
			sm_s2.m <= al_s1.sub ? ({1'b0, al_s1.m_big} - {1'b0, al_s1.m_small})
				: ({1'b0, al_s1.m_big} + {1'b0, al_s1.m_small});
			nm_s3 <= nm_c;
			rd_s4 <= rd_c;
		end
	end

	`FAS_ASSERT(a_flags_excl, !(v_s4 && rd_s4.overflow && rd_s4.underflow), "both flags set")
	`FAS_ASSERT_NEXT(a_hold, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(rd_s4), "output lost on stall")
	`FAS_ASSERT(a_norm, !v_s3 || nm_s3.zero || nm_s3.m[26], "sum not normalized")
endmodule

// ===== src/fas_align.sv =====
// fas_align: operand swap and alignment shift with sticky collapse.
// Depends on fas_pkg.
`timescale 1ns / 1ps
module fas_align import fas_pkg::*; (
	input  fas_in_t    in_item,
	output fas_align_t out_item
);
	logic [31:0] a, b, big, lesser;
	logic [30:0] ka, kb;
	logic [7:0]  es;
	logic [8:0]  d;
	logic [26:0] mb, ms, shifted, lost_mask;

	always_comb begin
		a = in_item.operand_a;
		b = in_item.operand_b ^ {in_item.mode, 31'd0};
		ka = ((a & ExpMask) == 32'd0) ? 31'd0 : a[30:0];
		kb = ((b & ExpMask) == 32'd0) ? 31'd0 : b[30:0];
		if (ka >= kb) begin
			big = a;
			lesser = b;
		end else begin
			big = b;
			lesser = a;
		end
		es = lesser[30:23];
		mb = (big[30:23] == 8'd0) ? 27'd0 : {1'b1, big[22:0], 3'b000};
		ms = (es == 8'd0) ? 27'd0 : {1'b1, lesser[22:0], 3'b000};
		d = {1'b0, big[30:23]} - {1'b0, es};
		// shifted-out bits fold into the sticky bit
		lost_mask = ~(27'h7FF_FFFF << d[4:0]);
		if (d > 9'd27) begin
			shifted = {26'd0, |ms};
		end else begin
			shifted = (ms >> d[4:0]) | {26'd0, |(ms & lost_mask)};
		end
		if (d <= 9'd27) begin
			out_item.m_small = shifted;
		end else begin
			out_item.m_small = {26'd0, |ms};
		end
		out_item.sign_r = big[31];
		out_item.sub = a[31] ^ b[31];
		out_item.e_big = big[30:23];
		out_item.m_big = mb;
	end
endmodule

// ===== src/fas_norm.sv =====
// fas_norm: leading-one normalization of the raw sum.
// Depends on fas_pkg.
`timescale 1ns / 1ps
module fas_norm import fas_pkg::*; (
	input  fas_sum_t  in_item,
	output fas_norm_t out_item
);
	logic [26:0] m1;
	logic [4:0]  lz;
	logic signed [10:0] e1;

	always_comb begin
		// carry out: shift right, keep sticky
		if (in_item.m[27]) begin
			m1 = in_item.m[27:1] | {26'd0, in_item.m[0]};
			e1 = $signed({1'b0, in_item.e}) + 11'sd1;
		end else begin
			m1 = in_item.m[26:0];
			e1 = $signed({1'b0, in_item.e});
		end
		// priority search for the leading one
		lz = 5'd0;
		for (int i = 0; i <= 26; i++) begin
			if (m1[i]) lz = 5'(26 - i);
		end
		out_item.sign_r = in_item.sign_r;
		out_item.zero = (in_item.m == 28'd0);
		out_item.m = m1 << lz;
		out_item.e = e1 - $signed({6'd0, lz});
	end
endmodule

// ===== src/fas_round.sv =====
// fas_round: round to nearest even, renormalize, pack with overflow/underflow.
// Depends on fas_pkg.
`timescale 1ns / 1ps
module fas_round import fas_pkg::*; (
	input  fas_norm_t in_item,
	output fas_out_t  out_item
);
	logic [24:0] r;
	logic signed [10:0] e;
	logic inc;

	always_comb begin
		inc = in_item.m[2] & (in_item.m[3] | (|in_item.m[1:0]));
		r = {1'b0, in_item.m[26:3]} + {24'd0, inc};
		e = in_item.e;
		if (r[24]) begin
			r = r >> 1;
			e = e + 11'sd1;
		end
		out_item.overflow = 1'b0;
		out_item.underflow = 1'b0;
		if (in_item.zero) begin
			out_item.sum_bits = 32'd0;
		end else if (e >= 11'sd255) begin
			out_item.sum_bits = {in_item.sign_r, 31'd0} | ExpMask;
			out_item.overflow = 1'b1;
		end else if (e <= 11'sd0) begin
			out_item.sum_bits = 32'd0;
			out_item.underflow = 1'b1;
		end else begin
			out_item.sum_bits = {in_item.sign_r, e[7:0], r[22:0] & FracMask[22:0]};
		end
	end
endmodule
